>>> design/scfd_pkg.sv
// shared constants and types for the serial frame deframer
// no dependencies; imported by every module of the block
`default_nettype none

package scfd_pkg;

    // frame layout
    localparam int unsigned WinLen    = 16;
    localparam int unsigned CountW    = $clog2(WinLen + 1);
    localparam int unsigned PayBytes  = 8;

    // sync markers and flag fields
    localparam logic [7:0] SYNC_HEAD  = 8'hAA;
    localparam logic [7:0] SYNC_CMD   = 8'h11;
    localparam logic [7:0] SYNC_TAIL  = 8'h55;
    localparam logic [7:0] LEN_MASK   = 8'h3F;
    localparam logic [7:0] REMOTE_BIT = 8'h80;
    localparam logic [5:0] MAX_LEN    = 6'd8;

    // one decoded frame
    typedef struct packed {
        logic [31:0] can_id;
        logic [63:0] payload;
        logic [3:0]  data_length;
    } scfd_result_t;

endpackage

`default_nettype wire

>>> design/scfd_window.sv
// byte window shift line, fill count, sync check and field extraction
// depends on scfd_pkg
`default_nettype none

module scfd_window (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 byte_accept,
    input  wire logic [7:0]           rx_byte,
    output logic                      res_valid,
    output scfd_pkg::scfd_result_t    res_data
);
    import scfd_pkg::*;

    logic [7:0]        win_reg  [WinLen];
    logic [7:0]        win_next [WinLen];
    logic [CountW-1:0] fill_count_reg;
    logic [CountW-1:0] fill_count_next;
    logic [CountW-1:0] fill_inc;
    logic              frame_match;
    logic [5:0]        len_raw;

    // window after the incoming byte: oldest drops out, newest at the end
    always_comb begin
        for (int i = 0; i < WinLen - 1; i++) begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WinLen - 1] = rx_byte;
    end

    // fill count saturates at a full window
    assign fill_inc = (fill_count_reg >= CountW'(WinLen)) ? CountW'(WinLen)
                                                          : fill_count_reg + CountW'(1);

    // frame found on the updated window
    assign frame_match = (fill_inc == CountW'(WinLen)) &&
                         (win_next[0] == SYNC_HEAD) &&
                         (win_next[1] == SYNC_CMD) &&
                         (win_next[WinLen - 1] == SYNC_TAIL);

    assign fill_count_next = frame_match ? '0 : fill_inc;

    // remote frames are consumed silently
    assign res_valid = byte_accept && frame_match &&
                       ((win_next[2] & REMOTE_BIT) == 8'h00);

    // field extraction
    assign len_raw = 6'(win_next[2] & LEN_MASK);

    always_comb begin
        res_data.can_id = {win_next[6], win_next[5], win_next[4], win_next[3]};
        for (int i = 0; i < PayBytes; i++) begin
            res_data.payload[8*i +: 8] = win_next[7 + i];
        end
        res_data.data_length = (len_raw > MAX_LEN) ? 4'(MAX_LEN) : len_raw[3:0];
    end

    // fill count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
        end else if (byte_accept) begin
            fill_count_reg <= fill_count_next;
        end
    end

    // window shift line, read only once filled
    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            for (int i = 0; i < WinLen; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/scfd_out_buf.sv
// result register with a skid stage so input can keep flowing under stall
// depends on scfd_pkg
`default_nettype none

module scfd_out_buf (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire scfd_pkg::scfd_result_t push_data,
    output logic                        space_ok,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output scfd_pkg::scfd_result_t      out_data
);
    import scfd_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    scfd_result_t main_data_reg;
    scfd_result_t skid_data_reg;
    logic         main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign space_ok  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> design/serial_can_frame_deframer_top.sv
// Serial CAN frame deframer: takes one received byte per transfer and emits
// one result per complete data frame (0xAA, 0x11, flags, 4 id bytes, 8 data
// bytes, 0x55). A byte is taken every cycle while s_ready is high; a decoded
// frame shows on m_ from the result register. The 16-byte window is a shift
// line, and all checks and field extraction sit between it and the result
// register, so throughput is one byte per cycle while s_ready is high. A
// two-entry output buffer keeps s_ready high while one result waits; s_ready
// drops only when two results are held. Remote frames (flags bit 7) are
// dropped quietly. Depends on scfd_pkg, scfd_window and scfd_out_buf.
`default_nettype none

module serial_can_frame_deframer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_can_id,
    output logic [63:0]      m_payload,
    output logic [3:0]       m_data_length
);
    import scfd_pkg::*;

    logic         byte_accept;
    logic         res_valid;
    scfd_result_t res_data;
    scfd_result_t out_data;

    // input transfer
    assign byte_accept = s_valid && s_ready;

    scfd_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    scfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_data),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // result fields
    assign m_can_id      = out_data.can_id;
    assign m_payload     = out_data.payload;
    assign m_data_length = out_data.data_length;

endmodule

`default_nettype wire

>>> verif/tb.sv
// self-checking testbench for serial_can_frame_deframer_top
// depends on scfd_pkg and the deframer rtl; frame decode is predicted in a scoreboard class
`timescale 1ns / 100ps

module tb;
    import scfd_pkg::*;

    localparam int unsigned RandBytes = 1800;
    localparam int unsigned IdleLimit = 4000;
    localparam int unsigned HoldCycles = 1000;
    localparam int unsigned HoldAfter = 20;
    localparam int unsigned MaxGap = 13;
    localparam int unsigned FrameLen = 16;

    // frame tracker: sliding byte window and queue of decoded frames still owed
    class frame_scoreboard;
        logic [7:0]   window [WinLen];
        int unsigned  fill;
        scfd_result_t owed_frames [$];
        int unsigned  errors;
        int unsigned  bytes_in;
        int unsigned  frames_out;
        int unsigned  remote_dropped;
        int unsigned  clamped_len;

        function new();
            fill = 0;
            errors = 0;
            bytes_in = 0;
            frames_out = 0;
            remote_dropped = 0;
            clamped_len = 0;
        endfunction

        // shift in one byte and queue a decoded frame when one completes
        function void note_byte(logic [7:0] rx);
            scfd_result_t frame;
            logic [5:0]   len;
            bytes_in++;
            if (fill >= WinLen) begin
                for (int i = 0; i < WinLen - 1; i++) window[i] = window[i + 1];
                window[WinLen - 1] = rx;
            end else begin
                window[fill] = rx;
                fill++;
            end
            if (fill != WinLen) return;
            if (window[0] != SYNC_HEAD || window[1] != SYNC_CMD ||
                window[WinLen - 1] != SYNC_TAIL) return;
            fill = 0;
            // remote frames are consumed silently
            if ((window[2] & REMOTE_BIT) != 8'h00) begin
                remote_dropped++;
                return;
            end
            frame.can_id = {window[6], window[5], window[4], window[3]};
            for (int i = 0; i < PayBytes; i++) frame.payload[8 * i +: 8] = window[7 + i];
            len = 6'(window[2] & LEN_MASK);
            if (len > MAX_LEN) begin
                len = MAX_LEN;
                clamped_len++;
            end
            frame.data_length = len[3:0];
            owed_frames.push_back(frame);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < 100)
                $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        // compare one result transfer against the oldest owed frame
        task check_result(scfd_result_t got);
            scfd_result_t want;
            if (owed_frames.size() == 0) begin
                report("unexpected frame", 64'(got.can_id), 64'h0);
                return;
            end
            want = owed_frames.pop_front();
            frames_out++;
            if (got.can_id != want.can_id)
                report("can_id", 64'(got.can_id), 64'(want.can_id));
            if (got.payload != want.payload) report("payload", got.payload, want.payload);
            if (got.data_length != want.data_length)
                report("data_length", 64'(got.data_length), 64'(want.data_length));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_can_id;
    logic [63:0] m_payload;
    logic [3:0]  m_data_length;

    frame_scoreboard sb = new();
    logic [7:0]      tx_stream [$];
    int unsigned     idle_cycles = 0;

    serial_can_frame_deframer_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_can_id      (m_can_id),
        .m_payload     (m_payload),
        .m_data_length (m_data_length)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // queue the first `keep` bytes of a frame with the given cmd and tail
    function automatic void push_frame(logic [7:0] cmd, logic [7:0] flags, logic [31:0] id,
                                       logic [63:0] pl, logic [7:0] tail, int unsigned keep);
        logic [7:0] bytes [FrameLen];
        bytes[0] = SYNC_HEAD;
        bytes[1] = cmd;
        bytes[2] = flags;
        for (int i = 0; i < 4; i++) bytes[3 + i] = id[8 * i +: 8];
        for (int i = 0; i < 8; i++) bytes[7 + i] = pl[8 * i +: 8];
        bytes[15] = tail;
        for (int i = 0; i < keep; i++) tx_stream.push_back(bytes[i]);
    endfunction

    // random flags: often a legal length, sometimes anything up to 63
    function automatic logic [7:0] rand_flags();
        logic [7:0] f;
        f = 8'($urandom);
        if ($urandom_range(0, 1) == 0) f[5:0] = 6'($urandom_range(0, 8));
        return f;
    endfunction

    // mostly well-formed frames, with noise, corrupted and truncated frames mixed in
    task automatic build_stream();
        int unsigned pick;
        int unsigned target;
        logic [7:0]  bad;
        // directed: resync byte, clamped-length data frame, remote frame
        tx_stream.push_back(8'hFF);
        push_frame(SYNC_CMD, 8'h7F, 32'hFF00_00FF, 64'h00FF_FF00_00FF_FF00, SYNC_TAIL,
                   FrameLen);
        push_frame(SYNC_CMD, 8'hBF, 32'h1234_5678, 64'hFFFF_0000_FFFF_0000, SYNC_TAIL,
                   FrameLen);
        target = tx_stream.size() + RandBytes;
        while (tx_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                push_frame(SYNC_CMD, rand_flags(), $urandom, {$urandom, $urandom},
                           SYNC_TAIL, FrameLen);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) tx_stream.push_back(8'($urandom));
            end else if (pick < 85) begin
                bad = SYNC_CMD ^ (8'h01 << $urandom_range(0, 7));
                push_frame(bad, rand_flags(), $urandom, {$urandom, $urandom},
                           SYNC_TAIL, FrameLen);
            end else if (pick < 90) begin
                bad = SYNC_TAIL ^ (8'h01 << $urandom_range(0, 7));
                push_frame(SYNC_CMD, rand_flags(), $urandom, {$urandom, $urandom},
                           bad, FrameLen);
            end else begin
                push_frame(SYNC_CMD, rand_flags(), $urandom, {$urandom, $urandom},
                           SYNC_TAIL, $urandom_range(1, FrameLen - 1));
            end
        end
    endtask

    // sender: one byte per transfer, random gaps with occasional back-to-back runs
    task automatic send_stream();
        int unsigned gap;
        bit          burst;
        burst = 1'b0;
        foreach (tx_stream[i]) begin
            if ($urandom_range(0, 63) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, MaxGap);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_rx_byte <= tx_stream[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    // receiver: random stalls per result, plus one long hold-off to fill the block
    task automatic take_results();
        int unsigned stall;
        int unsigned taken;
        bit          burst;
        bit          held;
        burst = 1'b0;
        held  = 1'b0;
        taken = 0;
        forever begin
            if ($urandom_range(0, 15) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, MaxGap);
            if (!held && taken >= HoldAfter) begin
                held  = 1'b1;
                stall = HoldCycles;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    endtask

    // monitor both channels on every edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_rx_byte);
            if (m_valid && m_ready) sb.check_result('{m_can_id, m_payload, m_data_length});
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IdleLimit) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // main sequence
    initial begin
        build_stream();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            take_results();
        join_none
        send_stream();
        // let the monitor record the last byte before looking at the owed queue
        @(posedge aclk);
        while (sb.owed_frames.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("sent %0d bytes; %0d data frames checked, %0d remote frames dropped",
                 sb.bytes_in, sb.frames_out, sb.remote_dropped);
        $display("%0d frames had a clamped length; %0d mismatches",
                 sb.clamped_len, sb.errors);
        if (sb.errors == 0 && sb.owed_frames.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/scfd_pkg.sv
design/scfd_window.sv
design/scfd_out_buf.sv
design/serial_can_frame_deframer_top.sv
verif/tb.sv
